FILE: rtl/core/frb_pkg.sv
// frb_pkg: shared constants, command and status codes, item structs and the
// capacity function of the frame record/replay buffer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frb_pkg;

  localparam int STORE_BYTES = 32768;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int LEN_W       = 15;
  localparam int CNT_W       = LEN_W + 2;
  localparam int CAP_W       = $clog2(STORE_BYTES + 1);
  localparam int CFG_W       = 5;
  localparam int SEC_BYTES   = 1000;
  localparam int CMD_W       = 3;
  localparam int ST_W        = 2;

  localparam logic [CFG_W-1:0] SECS_RESET = CFG_W'(10);

  localparam logic [CMD_W-1:0] CMD_BEGIN = 3'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_END   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [LEN_W-1:0] len;
    logic [7:0]       data;
  } frb_req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [7:0]       value;
    logic [LEN_W-1:0] flen;
    logic             last;
  } frb_res_t;

  // capacity in bytes, limited to the store size
  function automatic logic [CAP_W-1:0] capacity_of(input logic [CFG_W-1:0] secs);
    logic [CNT_W-1:0] c;
    c = (CNT_W'(secs) + CNT_W'(1)) * CNT_W'(SEC_BYTES);
    if (c > CNT_W'(STORE_BYTES)) begin
      capacity_of = CAP_W'(STORE_BYTES);
    end else begin
      capacity_of = c[CAP_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/frame_record_replay_buffer.sv
// frame_record_replay_buffer: top level with item handshakes, capacity register
// and result register; depends on frb_pkg and frb_core
//
// usage: items enter on in_valid/in_stall with in_command, in_frame_length and
// in_data_byte; every item gives exactly one result item on out_valid/out_stall.
// begin_write reserves a two-byte length word plus the payload, write_byte fills
// it, read_byte replays the frames one payload byte per item, end rewinds
// playback and clear empties the store. cfg_we/cfg_wdata set the recording time
// in seconds; capacity is (seconds+1)*1000 bytes. the user must write it only
// while idle; the block itself does not enforce this. write_byte, end, clear, a
// rejected begin_write, a read of an empty store and unknown commands give the
// result in the cycle after accept; begin_write adds state S_BW_HI, read_byte
// within a frame S_RD_FIN, and the read_byte that starts a frame fetches the
// length word first through S_RD_HI, S_RD_PAY and S_RD_FIN. one item is in work
// at a time, as the single port of the byte store does one access per cycle.
// reset clears all pointers and sets 10 seconds; store content is undefined
// until written and needs no clearing pass. while the receiver stalls, the
// result stays in the output register and in_stall holds new items off.
`timescale 1ns / 1ps
`default_nettype none

module frame_record_replay_buffer
  import frb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire logic [LEN_W-1:0] in_frame_length,
  input  wire logic [7:0]       in_data_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [ST_W-1:0]       out_status,
  output logic [7:0]            out_read_byte_value,
  output logic [LEN_W-1:0]      out_read_frame_length,
  output logic                  out_last_of_frame,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  logic             out_valid_r, out_valid_nxt;
  frb_res_t         res_r;
  frb_req_t         req;
  frb_res_t         res;
  logic             busy;
  logic             done;
  logic             start;

  assign in_stall = busy || (out_valid_r && out_stall);
  assign start    = in_valid && !in_stall;
  assign req      = '{cmd: in_command, len: in_frame_length, data: in_data_byte};

  frb_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .capacity (capacity_r),
    .busy     (busy),
    .done     (done),
    .res      (res)
  );

  always_comb begin
    capacity_nxt = capacity_r;
    if (cfg_we) begin
      capacity_nxt = capacity_of(cfg_wdata);
    end
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= capacity_of(SECS_RESET);
      out_valid_r <= 1'b0;
    end else begin
      capacity_r  <= capacity_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = res_r.status;
  assign out_read_byte_value   = res_r.value;
  assign out_read_frame_length = res_r.flen;
  assign out_last_of_frame     = res_r.last;

endmodule

`default_nettype wire

FILE: rtl/core/frb_core.sv
// frb_core: byte store and command sequencer of the frame record/replay buffer
// depends on frb_pkg; single-port store with registered read data
`timescale 1ns / 1ps
`default_nettype none

module frb_core
  import frb_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire frb_req_t         req,
  input  wire logic [CAP_W-1:0] capacity,
  output logic                  busy,
  output logic                  done,
  output frb_res_t              res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BW_HI  = 3'd1;
  localparam logic [2:0] S_RD_HI  = 3'd2;
  localparam logic [2:0] S_RD_PAY = 3'd3;
  localparam logic [2:0] S_RD_FIN = 3'd4;

  logic [7:0] mem [STORE_BYTES];

  logic [2:0]       state_r, state_nxt;
  logic [LEN_W-1:0] used_r, used_nxt;
  logic [LEN_W-1:0] rpos_r, rpos_nxt;
  logic [LEN_W-1:0] wcur_r, wcur_nxt;
  logic [LEN_W-1:0] wrem_r, wrem_nxt;
  logic [LEN_W-1:0] roff_r, roff_nxt;
  logic [LEN_W-1:0] cur_len_r, cur_len_nxt;
  logic [LEN_W-1:0] pend_len_r, pend_len_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [7:0]       rd_q_r;

  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;

  logic [CNT_W-1:0]  need;
  logic [CNT_W-1:0]  next_pos;
  logic              frame_last;
  logic [ADDR_W-1:0] pay_addr;

  assign need       = CNT_W'(used_r) + CNT_W'(req.len) + CNT_W'(2);
  assign next_pos   = CNT_W'(rpos_r) + CNT_W'(cur_len_r) + CNT_W'(2);
  assign frame_last = (cur_len_r == '0) ||
                      ((CNT_W'(roff_r) + CNT_W'(1)) >= CNT_W'(cur_len_r));
  assign pay_addr   = ADDR_W'(rpos_r + LEN_W'(2) + roff_r);
  assign busy       = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    rpos_nxt     = rpos_r;
    wcur_nxt     = wcur_r;
    wrem_nxt     = wrem_r;
    roff_nxt     = roff_r;
    cur_len_nxt  = cur_len_r;
    pend_len_nxt = pend_len_r;
    len_lo_nxt   = len_lo_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = '0;
    mem_wdata    = '0;
    done         = 1'b0;
    res          = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (req.cmd)
            CMD_BEGIN: begin
              if (need > CNT_W'(capacity)) begin
                done       = 1'b1;
                res.status = ST_FULL;
              end else begin
                mem_we       = 1'b1;
                mem_addr     = ADDR_W'(used_r);
                mem_wdata    = req.len[7:0];
                pend_len_nxt = req.len;
                state_nxt    = S_BW_HI;
              end
            end
            CMD_WRITE: begin
              done = 1'b1;
              if (wrem_r == '0) begin
                res.status = ST_IGNORED;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = ADDR_W'(wcur_r);
                mem_wdata = req.data;
                wcur_nxt  = wcur_r + LEN_W'(1);
                wrem_nxt  = wrem_r - LEN_W'(1);
              end
            end
            CMD_END: begin
              done     = 1'b1;
              rpos_nxt = '0;
              roff_nxt = '0;
            end
            CMD_CLEAR: begin
              done     = 1'b1;
              used_nxt = '0;
              rpos_nxt = '0;
              roff_nxt = '0;
              wrem_nxt = '0;
            end
            CMD_READ: begin
              if (used_r == '0) begin
                done       = 1'b1;
                res.status = ST_EMPTY;
              end else if (roff_r == '0) begin
                mem_re    = 1'b1;
                mem_addr  = ADDR_W'(rpos_r);
                state_nxt = S_RD_HI;
              end else begin
                mem_re    = 1'b1;
                mem_addr  = pay_addr;
                state_nxt = S_RD_FIN;
              end
            end
            default: begin
              done       = 1'b1;
              res.status = ST_IGNORED;
            end
          endcase
        end
      end
      S_BW_HI: begin
        mem_we    = 1'b1;
        mem_addr  = ADDR_W'(used_r + LEN_W'(1));
        mem_wdata = {1'b0, pend_len_r[LEN_W-1:8]};
        wcur_nxt  = used_r + LEN_W'(2);
        wrem_nxt  = pend_len_r;
        used_nxt  = used_r + pend_len_r + LEN_W'(2);
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD_HI: begin
        len_lo_nxt = rd_q_r;
        mem_re     = 1'b1;
        mem_addr   = ADDR_W'(rpos_r + LEN_W'(1));
        state_nxt  = S_RD_PAY;
      end
      S_RD_PAY: begin
        cur_len_nxt = {rd_q_r[6:0], len_lo_r};
        mem_re      = 1'b1;
        mem_addr    = pay_addr;
        state_nxt   = S_RD_FIN;
      end
      S_RD_FIN: begin
        done      = 1'b1;
        res.flen  = cur_len_r;
        res.value = (cur_len_r != '0) ? rd_q_r : 8'd0;
        res.last  = frame_last;
        if (frame_last) begin
          roff_nxt = '0;
          if (next_pos >= CNT_W'(used_r)) begin
            used_nxt = '0;
            rpos_nxt = '0;
            wrem_nxt = '0;
          end else begin
            rpos_nxt = next_pos[LEN_W-1:0];
          end
        end else begin
          roff_nxt = roff_r + LEN_W'(1);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      used_r    <= '0;
      rpos_r    <= '0;
      wcur_r    <= '0;
      wrem_r    <= '0;
      roff_r    <= '0;
      cur_len_r <= '0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      rpos_r    <= rpos_nxt;
      wcur_r    <= wcur_nxt;
      wrem_r    <= wrem_nxt;
      roff_r    <= roff_nxt;
      cur_len_r <= cur_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_len_r <= pend_len_nxt;
    len_lo_r   <= len_lo_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == S_IDLE))
    else $error("item started while sequencer busy");

  a_read_inside: assert property (@(posedge clk) disable iff (!rst_n)
    rpos_r <= used_r)
    else $error("read position beyond stored content");

  a_write_span: assert property (@(posedge clk) disable iff (!rst_n)
    (wrem_r != '0) |-> ((CNT_W'(wcur_r) + CNT_W'(wrem_r)) == CNT_W'(used_r)))
    else $error("outstanding payload does not end at used bytes");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (roff_r != '0) |-> (roff_r < cur_len_r))
    else $error("read offset past frame length");

endmodule

`default_nettype wire

FILE: tb/tb_frame_record_replay_buffer.sv
// tb_frame_record_replay_buffer: self-checking bench for the frame record/replay buffer,
// a queue-fed driver, a checking monitor and two behavioural copies of the byte store
// depends on frb_pkg and frame_record_replay_buffer
`timescale 1ns / 1ps

module tb_frame_record_replay_buffer;
  import frb_pkg::*;

  localparam int          PLAN           = 0;
  localparam int          CHK            = 1;
  localparam int          CMD_TOP        = (1 << CMD_W) - 1;
  localparam int unsigned LEN_TOP        = (1 << LEN_W) - 1;
  localparam int unsigned LEN_MASK       = 32'h7FFF;
  localparam int          RANDOM_ITEMS   = 1650;
  localparam int          PHASES         = 7;
  localparam int          WATCHDOG_LIMIT = 400;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CMD_W-1:0] in_command = '0;
  logic [LEN_W-1:0] in_frame_length = '0;
  logic [7:0]       in_data_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ST_W-1:0]  out_status;
  logic [7:0]       out_read_byte_value;
  logic [LEN_W-1:0] out_read_frame_length;
  logic             out_last_of_frame;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  frame_record_replay_buffer dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_frame_length       (in_frame_length),
    .in_data_byte          (in_data_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_read_byte_value   (out_read_byte_value),
    .out_read_frame_length (out_read_frame_length),
    .out_last_of_frame     (out_last_of_frame),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata)
  );

  always #4 clk = ~clk;

  // two copies of the buffer state: one runs ahead with the stimulus, one follows acceptance
  logic [7:0]  mem_img  [2][STORE_BYTES];
  bit          mem_seen [2][STORE_BYTES];
  int unsigned used_n  [2];
  int unsigned rd_pos  [2];
  int unsigned wr_cur  [2];
  int unsigned wr_left [2];
  int unsigned rd_off  [2];
  int unsigned cur_len [2];
  int unsigned secs    [2];

  frb_req_t cmd_backlog [$];
  frb_res_t due_results [$];

  int unsigned items_planned = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;

  function automatic int unsigned wrap_addr(input int unsigned a);
    return a % STORE_BYTES;
  endfunction

  function automatic int unsigned cap_bytes(input int s);
    int unsigned c;
    c = secs[s] * 1000 + 1000;
    return (c > STORE_BYTES) ? STORE_BYTES : c;
  endfunction

  function automatic void put_byte(input int s, input int unsigned a, input logic [7:0] v);
    mem_img[s][wrap_addr(a)] = v;
    mem_seen[s][wrap_addr(a)] = 1'b1;
  endfunction

  function automatic void model_reset(input int s);
    for (int i = 0; i < STORE_BYTES; i++) begin
      mem_img[s][i] = '0;
      mem_seen[s][i] = 1'b0;
    end
    used_n[s] = 0;
    rd_pos[s] = 0;
    wr_cur[s] = 0;
    wr_left[s] = 0;
    rd_off[s] = 0;
    cur_len[s] = 0;
    secs[s] = SECS_RESET;
  endfunction

  function automatic frb_res_t buffer_step(input int s, input frb_req_t it);
    frb_res_t    r;
    int unsigned len;
    r = '0;
    r.status = ST_OK;
    len = it.len;
    case (it.cmd)
      CMD_BEGIN: begin
        if (used_n[s] + len + 2 > cap_bytes(s)) begin
          r.status = ST_FULL;
        end else begin
          put_byte(s, used_n[s], len[7:0]);
          put_byte(s, used_n[s] + 1, len[15:8]);
          wr_cur[s] = (used_n[s] + 2) & LEN_MASK;
          wr_left[s] = len;
          used_n[s] = (used_n[s] + len + 2) & LEN_MASK;
        end
      end
      CMD_WRITE: begin
        if (wr_left[s] == 0) begin
          r.status = ST_IGNORED;
        end else begin
          put_byte(s, wr_cur[s], it.data);
          wr_cur[s] = (wr_cur[s] + 1) & LEN_MASK;
          wr_left[s] = wr_left[s] - 1;
        end
      end
      CMD_END: begin
        rd_pos[s] = 0;
        rd_off[s] = 0;
      end
      CMD_CLEAR: begin
        used_n[s] = 0;
        rd_pos[s] = 0;
        rd_off[s] = 0;
        wr_left[s] = 0;
      end
      CMD_READ: begin
        if (used_n[s] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (rd_off[s] == 0) begin
            cur_len[s] = {mem_img[s][wrap_addr(rd_pos[s] + 1)],
                          mem_img[s][wrap_addr(rd_pos[s])]} & LEN_MASK;
          end
          r.flen = LEN_W'(cur_len[s]);
          if (cur_len[s] != 0) begin
            r.value = mem_img[s][wrap_addr(rd_pos[s] + 2 + rd_off[s])];
          end
          if (cur_len[s] == 0 || rd_off[s] + 1 >= cur_len[s]) begin
            r.last = 1'b1;
            rd_pos[s] = rd_pos[s] + cur_len[s] + 2;
            rd_off[s] = 0;
            if (rd_pos[s] >= used_n[s]) begin
              used_n[s] = 0;
              rd_pos[s] = 0;
              wr_left[s] = 0;
            end
            rd_pos[s] = rd_pos[s] & LEN_MASK;
          end else begin
            rd_off[s] = rd_off[s] + 1;
          end
        end
      end
      default: begin
        r.status = ST_IGNORED;
      end
    endcase
    return r;
  endfunction

  // a read must never touch a reserved byte that was never written
  function automatic bit plan_read_safe();
    int unsigned l;
    if (used_n[PLAN] == 0) return 1'b1;
    l = cur_len[PLAN];
    if (rd_off[PLAN] == 0) begin
      if (!mem_seen[PLAN][wrap_addr(rd_pos[PLAN])] ||
          !mem_seen[PLAN][wrap_addr(rd_pos[PLAN] + 1)]) return 1'b0;
      l = {mem_img[PLAN][wrap_addr(rd_pos[PLAN] + 1)],
           mem_img[PLAN][wrap_addr(rd_pos[PLAN])]} & LEN_MASK;
    end
    if (l == 0) return 1'b1;
    return mem_seen[PLAN][wrap_addr(rd_pos[PLAN] + 2 + rd_off[PLAN])];
  endfunction

  function automatic void queue_item(input logic [CMD_W-1:0] c, input int unsigned len,
                                     input logic [7:0] d);
    frb_req_t it;
    if (c == CMD_READ && !plan_read_safe()) begin
      c = (wr_left[PLAN] > 0) ? CMD_WRITE : CMD_CLEAR;
    end
    it.cmd = c;
    it.len = LEN_W'(len);
    it.data = d;
    void'(buffer_step(PLAN, it));
    cmd_backlog.push_back(it);
    items_planned++;
  endfunction

  task automatic set_seconds(input int unsigned v);
    while (results_seen != items_planned) @(posedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    secs[PLAN] = v;
    secs[CHK] = v;
  endtask

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // driver
  int send_wait = 0;
  bit send_calm = 1'b0;

  always @(posedge clk) begin : drive_p
    frb_req_t nxt;
    frb_req_t got;
    logic     drive;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      drive = in_valid;
      if (in_valid && !in_stall) begin
        got.cmd = in_command;
        got.len = in_frame_length;
        got.data = in_data_byte;
        due_results.push_back(buffer_step(CHK, got));
        drive = 1'b0;
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        send_wait = send_calm ? 0 : $urandom_range(0, 18);
      end
      if (!drive) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (cmd_backlog.size() > 0) begin
          nxt = cmd_backlog.pop_front();
          in_command <= nxt.cmd;
          in_frame_length <= nxt.len;
          in_data_byte <= nxt.data;
          drive = 1'b1;
        end
      end
      in_valid <= drive;
    end
  end

  // monitor
  int stall_wait = 0;
  bit recv_calm = 1'b0;

  always @(posedge clk) begin : watch_p
    frb_res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: extra item, expected none, actual status %0d value %0d len %0d last %0d",
                   $time, out_status, out_read_byte_value, out_read_frame_length,
                   out_last_of_frame);
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("read_byte_value", want.value, out_read_byte_value);
          check_field("read_frame_length", want.flen, out_read_frame_length);
          check_field("last_of_frame", want.last, out_last_of_frame);
          results_seen++;
        end
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        stall_wait = recv_calm ? 0 : $urandom_range(0, 18);
      end
      if (stall_wait > 0) begin
        out_stall <= 1'b1;
        stall_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus_p
    int unsigned phase_secs [PHASES];
    int unsigned stop, len, fill, space, guard, pick;
    bit          rewound;
    model_reset(PLAN);
    model_reset(CHK);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    set_seconds(SECS_RESET);
    queue_item(CMD_READ, 0, 8'h00);
    queue_item(CMD_WRITE, LEN_TOP, 8'hFF);
    for (int c = CMD_READ + 1; c <= CMD_TOP; c++) begin
      queue_item(CMD_W'(c), $urandom, 8'($urandom));
    end
    queue_item(CMD_BEGIN, 0, 8'h00);
    queue_item(CMD_READ, 0, 8'h00);
    queue_item(CMD_BEGIN, 32766, 8'h00);
    queue_item(CMD_BEGIN, 2, 8'h00);
    queue_item(CMD_WRITE, 0, 8'h00);
    queue_item(CMD_WRITE, 0, 8'hFF);
    queue_item(CMD_WRITE, 0, 8'hA5);
    queue_item(CMD_BEGIN, 3, 8'h00);
    queue_item(CMD_WRITE, 0, 8'h5A);
    queue_item(CMD_BEGIN, 1, 8'h00);
    queue_item(CMD_WRITE, 0, 8'h3C);
    queue_item(CMD_READ, 0, 8'h00);
    queue_item(CMD_END, 0, 8'h00);
    queue_item(CMD_READ, 0, 8'h00);
    queue_item(CMD_READ, 0, 8'h00);
    queue_item(CMD_READ, 0, 8'h00);
    queue_item(CMD_CLEAR, LEN_TOP, 8'hFF);
    queue_item(CMD_READ, 0, 8'h00);

    // largest reservation that fits, then capacity shrunk below the content
    set_seconds(31);
    queue_item(CMD_BEGIN, 31998, 8'h00);
    queue_item(CMD_BEGIN, 0, 8'h00);
    queue_item(CMD_BEGIN, 4, 8'h00);
    repeat (4) queue_item(CMD_WRITE, 0, 8'($urandom));
    set_seconds(1);
    queue_item(CMD_BEGIN, 1993, 8'h00);
    queue_item(CMD_BEGIN, 1992, 8'h00);
    queue_item(CMD_BEGIN, 0, 8'h00);
    repeat (4) queue_item(CMD_READ, 0, 8'h00);
    queue_item(CMD_CLEAR, 0, 8'h00);

    phase_secs = '{31, 1, $urandom_range(1, 31), 2, 31, $urandom_range(1, 31), 10};
    for (int p = 0; p < PHASES; p++) begin
      set_seconds(phase_secs[p]);
      stop = items_planned + RANDOM_ITEMS / PHASES;
      while (items_planned < stop) begin
        if ($urandom_range(0, 6) == 0) begin
          // noise
          repeat ($urandom_range(1, 12)) begin
            len = $urandom_range(0, 1) ? $urandom_range(0, LEN_TOP) : $urandom_range(0, 12);
            queue_item(CMD_W'($urandom_range(0, CMD_TOP)), len, 8'($urandom));
          end
        end else begin
          repeat ($urandom_range(1, 4)) begin
            pick = $urandom_range(0, 99);
            space = (cap_bytes(PLAN) >= used_n[PLAN] + 2) ?
                    cap_bytes(PLAN) - used_n[PLAN] - 2 : 0;
            if (pick < 60) len = $urandom_range(0, 12);
            else if (pick < 85) len = $urandom_range(13, 80);
            else if (pick < 90) len = space;
            else if (pick < 95) len = space + 1;
            else len = $urandom_range(0, LEN_TOP);
            queue_item(CMD_BEGIN, len, 8'($urandom));
            fill = (len <= 200) ? len : $urandom_range(0, 3);
            if ($urandom_range(0, 11) == 0) fill = $urandom_range(0, fill);
            repeat (fill) queue_item(CMD_WRITE, $urandom, 8'($urandom));
            if ($urandom_range(0, 7) == 0) queue_item(CMD_WRITE, $urandom, 8'($urandom));
          end
          if ($urandom_range(0, 3) != 0) begin
            rewound = 1'b0;
            guard = 0;
            while (used_n[PLAN] != 0 && guard < 400 && items_planned < stop) begin
              if (!rewound && $urandom_range(0, 40) == 0) begin
                queue_item(CMD_END, $urandom, 8'($urandom));
                rewound = 1'b1;
              end else begin
                queue_item(CMD_READ, $urandom, 8'($urandom));
              end
              guard++;
            end
            repeat ($urandom_range(0, 2)) queue_item(CMD_READ, $urandom, 8'($urandom));
          end
        end
      end
    end

    while (results_seen != items_planned) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
